@@ sv/scb_pkg.sv @@
// Shared types, constants and helpers for the scaled color-key blitter.
package scb_pkg;

  localparam int unsigned ImageDepth = 4096;
  localparam int unsigned IdxW       = $clog2(ImageDepth);
  localparam int unsigned CoordW     = 11;
  localparam int unsigned RegW       = 12;
  localparam int unsigned SizeW      = 7;
  localparam int unsigned ColorW     = 32;
  localparam int unsigned AddrW      = 22;
  localparam int unsigned ProdW      = RegW + SizeW;
  localparam int unsigned MulW       = 2 * SizeW;

  localparam int unsigned SIn    = 0;
  localparam int unsigned SPre   = 1;
  localparam int unsigned SFix   = SPre + ProdW + 1;
  localparam int unsigned SIdx   = SFix + 1;
  localparam int unsigned SMem   = SIdx + 1;
  localparam int unsigned NStage = SMem + 1;

  localparam logic [ColorW-1:0] KeyWhite = 32'h00ff_ffff;
  localparam logic [ColorW-1:0] KeyBlack = 32'h0000_0000;

  typedef enum logic [2:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_TOP    = 3'd1,
    REG_RECT_RIGHT  = 3'd2,
    REG_RECT_BOTTOM = 3'd3,
    REG_SRC_WIDTH   = 3'd4,
    REG_SRC_HEIGHT  = 3'd5,
    REG_WIN_WIDTH   = 3'd6,
    REG_WIN_HEIGHT  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [RegW-1:0]  rem;
    logic [ProdW-1:0] quo;
    logic [ProdW-1:0] dvd;
    logic [RegW-1:0]  dsr;
    logic             zero;
    logic [SizeW-1:0] size;
  } div_t;

  typedef struct packed {
    logic              draw;
    logic [IdxW-1:0]   ld_idx;
    logic [ColorW-1:0] ld_color;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [AddrW-1:0]  addr;
    logic              in_rect;
    div_t              div_y;
    div_t              div_x;
    logic [SizeW-1:0]  col;
    logic [MulW-1:0]   rowmul;
    logic [IdxW-1:0]   src_idx;
  } item_t;

  function automatic div_t div_step(div_t d);
    logic [RegW:0] remsh;
    div_t          r;
    r     = d;
    remsh = {d.rem, d.dvd[ProdW-1]};
    if (remsh >= {1'b0, d.dsr}) begin
      remsh = remsh - {1'b0, d.dsr};
      r.quo = {d.quo[ProdW-2:0], 1'b1};
    end else begin
      r.quo = {d.quo[ProdW-2:0], 1'b0};
    end
    r.rem = remsh[RegW-1:0];
    r.dvd = {d.dvd[ProdW-2:0], 1'b0};
    return r;
  endfunction

  function automatic logic [SizeW-1:0] div_fix(div_t d);
    logic [SizeW-1:0] r;
    r = '0;
    if (!d.zero && d.quo != ProdW'(d.size)) begin
      r = d.quo[SizeW-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/scaled_colorkey_blitter_top.sv @@
// Top level of the scaled color-key blitter: config registers, pipeline, image store.
//
// Input stream s_axis: tuser carries the item kind (0 load, 1 draw). A load item
// writes pixel_color into the source image at pixel_index; a draw item names one
// destination pixel and yields one result on m_axis. Loads yield no result.
// The source row and column are found by pipelined restoring dividers, one
// quotient bit per stage (19 stages for each coordinate, in parallel), followed
// by fix, index, image read and output stages.
// A draw item passes the pre, divider, fix, index and memory stages and the output register before m_axis.
// Throughput: one item per cycle while m_axis does not stall; loads and draws may be mixed freely.
// Loads write the image at the same stage where draws read it, so item order
// holds for read-after-write.
// Reset clears the valid bits and sets the config registers to their defaults;
// the image content is undefined until written and needs no clearing pass.
// When m_axis stalls with a result pending, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
// Config writes (cfg_we_i, cfg_addr_i, cfg_data_i) are meant for idle periods.
module scaled_colorkey_blitter_top
  import scb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // pixel_index, pixel_color, dest_x, dest_y, zero pad
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // dest_address, out_color, write_enable, zero pad
);

  logic [RegW-1:0]  rect_left_q, rect_top_q, rect_right_q, rect_bottom_q;
  logic [SizeW-1:0] src_w_q, src_h_q;
  logic [RegW-1:0]  win_w_q, win_h_q;

  item_t             pipe_q [NStage];
  item_t             pipe_d [NStage];
  logic [NStage-1:0] valid_q;
  logic              en;
  logic [ColorW-1:0] img_mem [ImageDepth];
  logic [ColorW-1:0] rd_q;
  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [ColorW-1:0] out_color_q;
  logic              out_we_q;
  logic [ColorW-1:0] color_sel;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= 12'd0;
      rect_top_q    <= 12'd0;
      rect_right_q  <= 12'd63;
      rect_bottom_q <= 12'd63;
      src_w_q       <= 7'd64;
      src_h_q       <= 7'd64;
      win_w_q       <= 12'd640;
      win_h_q       <= 12'd480;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_RECT_LEFT:   rect_left_q   <= cfg_data_i;
        REG_RECT_TOP:    rect_top_q    <= cfg_data_i;
        REG_RECT_RIGHT:  rect_right_q  <= cfg_data_i;
        REG_RECT_BOTTOM: rect_bottom_q <= cfg_data_i;
        REG_SRC_WIDTH:   src_w_q       <= cfg_data_i[SizeW-1:0];
        REG_SRC_HEIGHT:  src_h_q       <= cfg_data_i[SizeW-1:0];
        REG_WIN_WIDTH:   win_w_q       <= cfg_data_i;
        REG_WIN_HEIGHT:  win_h_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [RegW:0] x13, y13, l13, t13, r13, b13, offx, offy, spanx, spany;
    pipe_d = pipe_q;

    pipe_d[SIn].draw     = s_axis_tuser;
    pipe_d[SIn].ld_idx   = s_axis_tdata[11:0];
    pipe_d[SIn].ld_color = s_axis_tdata[43:12];
    pipe_d[SIn].x        = s_axis_tdata[54:44];
    pipe_d[SIn].y        = s_axis_tdata[65:55];

    x13   = {2'b00, pipe_q[SIn].x};
    y13   = {2'b00, pipe_q[SIn].y};
    l13   = {rect_left_q[RegW-1], rect_left_q};
    t13   = {rect_top_q[RegW-1], rect_top_q};
    r13   = {rect_right_q[RegW-1], rect_right_q};
    b13   = {rect_bottom_q[RegW-1], rect_bottom_q};
    offx  = x13 - l13;
    offy  = y13 - t13;
    spanx = r13 - l13;
    spany = b13 - t13;

    pipe_d[SPre] = pipe_q[SIn];
    pipe_d[SPre].addr = AddrW'(pipe_q[SIn].x)
                      + AddrW'(pipe_q[SIn].y) * AddrW'(win_w_q);
    pipe_d[SPre].in_rect = ($signed(x13) >= $signed(l13)) && ($signed(x13) <= $signed(r13))
                        && ($signed(y13) >= $signed(t13)) && ($signed(y13) <= $signed(b13))
                        && ({1'b0, pipe_q[SIn].x} < win_w_q)
                        && ({1'b0, pipe_q[SIn].y} < win_h_q);
    pipe_d[SPre].div_y.rem  = '0;
    pipe_d[SPre].div_y.quo  = '0;
    pipe_d[SPre].div_y.dvd  = ProdW'(offy[RegW-1:0]) * ProdW'(src_h_q);
    pipe_d[SPre].div_y.dsr  = spany[RegW-1:0];
    pipe_d[SPre].div_y.zero = (spany[RegW-1:0] == '0) || (src_h_q == '0);
    pipe_d[SPre].div_y.size = src_h_q;
    pipe_d[SPre].div_x.rem  = '0;
    pipe_d[SPre].div_x.quo  = '0;
    pipe_d[SPre].div_x.dvd  = ProdW'(offx[RegW-1:0]) * ProdW'(src_w_q);
    pipe_d[SPre].div_x.dsr  = spanx[RegW-1:0];
    pipe_d[SPre].div_x.zero = (spanx[RegW-1:0] == '0) || (src_w_q == '0);
    pipe_d[SPre].div_x.size = src_w_q;

    for (int k = SPre + 1; k < SFix; k++) begin
      pipe_d[k]       = pipe_q[k-1];
      pipe_d[k].div_y = div_step(pipe_q[k-1].div_y);
      pipe_d[k].div_x = div_step(pipe_q[k-1].div_x);
    end

    pipe_d[SFix]        = pipe_q[SFix-1];
    pipe_d[SFix].col    = div_fix(pipe_q[SFix-1].div_x);
    pipe_d[SFix].rowmul = MulW'(div_fix(pipe_q[SFix-1].div_y)) * MulW'(src_w_q);

    pipe_d[SIdx] = pipe_q[SFix];
    if (src_w_q == '0 || src_h_q == '0) begin
      pipe_d[SIdx].src_idx = '0;
    end else begin
      pipe_d[SIdx].src_idx = IdxW'(pipe_q[SFix].rowmul + MulW'(pipe_q[SFix].col));
    end

    pipe_d[SMem] = pipe_q[SIdx];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NStage; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NStage-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_q[SIdx]) begin
      if (!pipe_q[SIdx].draw) begin
        img_mem[pipe_q[SIdx].ld_idx] <= pipe_q[SIdx].ld_color;
      end else begin
        rd_q <= img_mem[pipe_q[SIdx].src_idx];
      end
    end
  end

  assign color_sel = pipe_q[SMem].in_rect ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[SMem] && pipe_q[SMem].draw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_addr_q  <= pipe_q[SMem].addr;
      out_color_q <= color_sel;
      out_we_q    <= pipe_q[SMem].in_rect && color_sel != KeyWhite && color_sel != KeyBlack;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_we_q, out_color_q, out_addr_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[54] |->
      m_axis_tdata[53:22] != KeyWhite && m_axis_tdata[53:22] != KeyBlack)
    else $error("write enable set on a key color");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[SFix-1] && pipe_q[SFix-1].in_rect && !pipe_q[SFix-1].div_y.zero |->
      pipe_q[SFix-1].div_y.quo <= ProdW'(pipe_q[SFix-1].div_y.size))
    else $error("row quotient exceeds source height");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_q[SMem]))
    else $error("result without a pipeline item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(valid_q))
    else $error("pipeline advanced during stall");

endmodule
